// ----- rtl/uspc_pkg.sv -----
`timescale 1ns / 1ps
package uspc_pkg;
    localparam int MaxVerts = 64;
    localparam int IdxW = $clog2(MaxVerts);
    localparam int CntW = $clog2(MaxVerts + 1);
    localparam int VtxW = 3 * 32 + 4 * 24;
    localparam logic signed [24:0] UnitCoord = 25'sd65536;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [23:0] lu;
        logic signed [23:0] lv;
        logic signed [23:0] ts;
        logic signed [23:0] tt;
    } t_vtx;

    function automatic logic plane_inside(input logic [1:0] plane, input t_vtx v);
        logic r;
        unique case (plane)
            2'd0: r = 25'(v.tt) < UnitCoord;
            2'd1: r = v.ts > 24'sd0;
            2'd2: r = 25'(v.ts) < UnitCoord;
            default: r = v.tt > 24'sd0;
        endcase
        return r;
    endfunction
endpackage

// ----- rtl/uspc_ram.sv -----
`timescale 1ns / 1ps
module uspc_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/uspc_div.sv -----
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module uspc_div import uspc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [25:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quo
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [25:0] r_d;
    logic        r_neg, r_busy;
    logic [6:0]  r_cnt;
    logic [64:0] w_sh;
    logic [63:0] w_an;

    assign w_an = i_num[63] ? 64'(-i_num) : 64'(i_num);
    always_comb begin
        w_sh  = {r_rem[63:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= 65'(r_d)) begin
            n_rem = w_sh - 65'(r_d);
            n_q[0] = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= w_an;
                r_rem  <= '0;
                r_d    <= i_den[25] ? 26'(-i_den) : 26'(i_den);
                r_neg  <= i_num[63] ^ i_den[25];
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ----- rtl/unit_square_polygon_clipper_top.sv -----
`timescale 1ns / 1ps
// Clips one polygon against the texture-space unit square (t<1, s>0, s<1, t>0 in turn)
// with Sutherland-Hodgman in fixed point. Vertices are taken one item per cycle while
// the input is not stalled, and stored. The item that carries last_vertex starts four
// clip passes, and the block stalls its input from then until the last result item has
// left. Each pass reads the last stored vertex, then reads every stored vertex in turn
// and writes any crossing and each kept vertex. Every crossing runs seven 64-step serial
// divisions through one shared divider. When the quad test is armed and four vertices
// remain, they are checked before any item leaves. The clipped vertices then leave one
// per item, with the last one marked. When nothing survives, one empty-marked item
// leaves instead. The two vertex stores are a ping-pong pair of RAMs.
module unit_square_polygon_clipper_top import uspc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [23:0] i_light_u,
    input  logic signed [23:0] i_light_v,
    input  logic signed [23:0] i_tex_s,
    input  logic signed [23:0] i_tex_t,
    input  logic               i_clip_test,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [23:0] o_out_light_u,
    output logic signed [23:0] o_out_light_v,
    output logic signed [23:0] o_out_tex_s,
    output logic signed [23:0] o_out_tex_t,
    output logic [6:0]         o_out_count,
    output logic               o_is_empty,
    output logic               o_no_clip,
    output logic               o_overflow,
    output logic               o_last_out
);
    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_PREV  = 10'b0000000010,
        S_PWAIT = 10'b0000000100,
        S_CUR   = 10'b0000001000,
        S_CWAIT = 10'b0000010000,
        S_DECIDE= 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_OREAD = 10'b0010000000,
        S_OWAIT = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic   r_bank;              // which RAM holds the current stage input
    logic [1:0] r_plane;
    logic [CntW-1:0] r_cnt, r_n, r_j;
    logic   r_test, r_ovf, r_nc, r_empty;
    t_vtx   r_s, r_p, r_x, r_a, r_b;
    logic   r_xpend, r_ppend;    // crossing then point still to push
    logic [2:0] r_k;
    logic   r_divgo;

    // RAM pair
    logic we0, we1;
    logic [IdxW-1:0] wa, ra;
    t_vtx wd, rd0, rd1, rd;
    uspc_ram #(.Width(VtxW), .Depth(MaxVerts)) u_ram0 (
        .i_clk, .i_we(we0), .i_waddr(wa), .i_wdata(wd), .i_raddr(ra), .o_rdata(rd0));
    uspc_ram #(.Width(VtxW), .Depth(MaxVerts)) u_ram1 (
        .i_clk, .i_we(we1), .i_waddr(wa), .i_wdata(wd), .i_raddr(ra), .o_rdata(rd1));
    assign rd = r_bank ? rd1 : rd0;

    logic accept;
    assign o_stall = (r_state != S_LOAD);
    assign accept = i_valid && !o_stall;

    // Crossing setup for current plane with a=r_a, b=r_b.
    logic signed [25:0] num, den;
    always_comb begin
        unique case (r_plane)
            2'd0: begin num = 26'sd65536 - 26'(r_a.tt); den = 26'(r_b.tt) - 26'(r_a.tt); end
            2'd1: begin num = 26'(r_a.ts); den = 26'(r_a.ts) - 26'(r_b.ts); end
            2'd2: begin num = 26'sd65536 - 26'(r_a.ts); den = 26'(r_b.ts) - 26'(r_a.ts); end
            default: begin num = 26'(r_a.tt); den = 26'(r_a.tt) - 26'(r_b.tt); end
        endcase
    end
    logic signed [32:0] fa, fb;
    always_comb begin
        unique case (r_k)
            3'd0: begin fa = 33'(r_a.px); fb = 33'(r_b.px); end
            3'd1: begin fa = 33'(r_a.py); fb = 33'(r_b.py); end
            3'd2: begin fa = 33'(r_a.pz); fb = 33'(r_b.pz); end
            3'd3: begin fa = 33'(r_a.lu); fb = 33'(r_b.lu); end
            3'd4: begin fa = 33'(r_a.lv); fb = 33'(r_b.lv); end
            3'd5: begin fa = 33'(r_a.ts); fb = 33'(r_b.ts); end
            default: begin fa = 33'(r_a.tt); fb = 33'(r_b.tt); end
        endcase
    end
    logic signed [33:0] diff;
    logic signed [63:0] r_prod;
    logic div_done;
    logic signed [63:0] quo;
    logic signed [63:0] sum;
    assign diff = 34'(fb) - 34'(fa);
    uspc_div u_div (.i_clk, .i_rst_n, .i_start(r_divgo), .i_num(r_prod), .i_den(den),
        .o_done(div_done), .o_quo(quo));
    assign sum = 64'(fa) + quo;

    logic in_s, in_p;
    assign in_s = plane_inside(r_plane, r_s);
    assign in_p = plane_inside(r_plane, r_p);

    logic [IdxW-1:0] jm;
    assign jm = r_j[IdxW-1:0];

    // The four survivors are checked against the unit square before any item leaves.
    logic quad_chk;
    assign quad_chk = !r_empty && (r_k != 3'd7) && r_test && (r_cnt == CntW'(4));

    always_comb begin
        we0 = 1'b0; we1 = 1'b0; wa = r_n[IdxW-1:0]; wd = r_p; ra = jm;
        if (r_state == S_LOAD) begin
            we0 = accept && (r_cnt < CntW'(MaxVerts));
            wa  = r_cnt[IdxW-1:0];
            wd  = '{i_pos_x, i_pos_y, i_pos_z, i_light_u, i_light_v, i_tex_s, i_tex_t};
        end else if (r_state == S_PREV) begin
            ra = IdxW'(r_cnt - CntW'(1));
        end else if (r_state == S_DECIDE && (r_xpend || r_ppend) &&
                     r_n < CntW'(MaxVerts)) begin
            wd = r_xpend ? r_x : r_p;
            if (r_bank) we0 = 1'b1; else we1 = 1'b1;
        end else if (r_state == S_OWAIT && quad_chk) begin
            // The read is registered, so the next vertex is addressed while the current one is checked.
            ra = (r_j == CntW'(3)) ? '0 : IdxW'(r_j + CntW'(1));
        end else if (r_state == S_OUT) begin
            ra = IdxW'(r_j + CntW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0; r_test <= 1'b0; r_ovf <= 1'b0; r_bank <= 1'b0;
            o_valid <= 1'b0; r_divgo <= 1'b0;
        end else begin
            r_divgo <= (r_state == S_DIV) && !r_divgo && !u_div.r_busy && !div_done &&
                       (den != '0);
            unique case (r_state)
                S_LOAD: if (accept) begin
                    if (i_clip_test) r_test <= 1'b1;
                    if (r_cnt < CntW'(MaxVerts)) r_cnt <= r_cnt + CntW'(1);
                    else r_ovf <= 1'b1;
                    if (i_last_vertex) begin
                        r_plane <= 2'd0; r_bank <= 1'b0; r_state <= S_PREV;
                    end
                end
                S_PREV: begin
                    r_n <= '0; r_j <= '0;
                    if (r_cnt == '0) begin
                        if (r_plane == 2'd3) r_state <= S_OREAD;
                        else begin r_plane <= r_plane + 2'd1; r_bank <= ~r_bank; end
                    end else r_state <= S_PWAIT;
                end
                S_PWAIT: begin r_s <= rd; r_state <= S_CUR; end
                S_CUR: r_state <= S_CWAIT;
                S_CWAIT: begin
                    r_p <= rd;
                    r_ppend <= plane_inside(r_plane, rd);
                    r_xpend <= plane_inside(r_plane, rd) != in_s;
                    if (plane_inside(r_plane, rd) != in_s) begin
                        // The crossing always runs from the outside end to the inside end.
                        r_k <= 3'd0; r_state <= S_DIV;
                        if (in_s) begin r_a <= rd; r_b <= r_s; end
                        else begin r_a <= r_s; r_b <= rd; end
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DIV: begin
                    // multiply registered, then a serial divide for each field
                    if (!r_divgo && !u_div.r_busy && !div_done) begin
                        if (den == '0) begin r_x <= r_a; r_state <= S_DECIDE; end
                        else r_prod <= 64'(diff) * 64'(num);
                    end else if (div_done) begin
                        unique case (r_k)
                            3'd0: r_x.px <= 32'(sum);
                            3'd1: r_x.py <= 32'(sum);
                            3'd2: r_x.pz <= 32'(sum);
                            3'd3: r_x.lu <= 24'(sum);
                            3'd4: r_x.lv <= 24'(sum);
                            3'd5: r_x.ts <= 24'(sum);
                            default: r_x.tt <= 24'(sum);
                        endcase
                        if (r_k == 3'd6) r_state <= S_DECIDE;
                        else r_k <= r_k + 3'd1;
                    end
                end
                S_DECIDE: begin
                    if (r_xpend || r_ppend) begin
                        if (r_n < CntW'(MaxVerts)) r_n <= r_n + CntW'(1);
                        else r_ovf <= 1'b1;
                        if (r_xpend) r_xpend <= 1'b0; else r_ppend <= 1'b0;
                    end else begin
                        r_s <= r_p;
                        if (r_j + CntW'(1) == r_cnt) begin
                            r_cnt <= r_n; r_bank <= ~r_bank; r_j <= '0;
                            if (r_plane == 2'd3) r_state <= S_OREAD;
                            else begin r_plane <= r_plane + 2'd1; r_state <= S_PREV; end
                        end else begin
                            r_j <= r_j + CntW'(1); r_state <= S_CUR;
                        end
                    end
                end
                S_OREAD: begin
                    r_nc <= r_test && (r_cnt == CntW'(4));
                    r_empty <= (r_cnt == '0);
                    r_k <= 3'd0;
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    // an empty result emits its marker; else an armed quad is checked first, then items are emitted
                    if (r_empty) begin
                        o_valid <= 1'b1; o_out_pos_x <= '0; o_out_pos_y <= '0;
                        o_out_pos_z <= '0; o_out_light_u <= '0; o_out_light_v <= '0;
                        o_out_tex_s <= '0; o_out_tex_t <= '0; o_out_count <= '0;
                        o_is_empty <= 1'b1; o_no_clip <= 1'b0; o_overflow <= r_ovf;
                        o_last_out <= 1'b1; r_state <= S_OUT;
                    end else if (quad_chk) begin
                        if ((rd.ts != 24'sd0 && 25'(rd.ts) != UnitCoord) ||
                            (rd.tt != 24'sd0 && 25'(rd.tt) != UnitCoord)) r_nc <= 1'b0;
                        if (r_j == CntW'(3)) begin r_j <= '0; r_k <= 3'd7; end
                        else r_j <= r_j + CntW'(1);
                    end else begin
                        r_k <= 3'd7;
                        o_valid <= 1'b1;
                        o_out_pos_x <= rd.px; o_out_pos_y <= rd.py; o_out_pos_z <= rd.pz;
                        o_out_light_u <= rd.lu; o_out_light_v <= rd.lv;
                        o_out_tex_s <= rd.ts; o_out_tex_t <= rd.tt;
                        o_out_count <= 7'(r_cnt); o_is_empty <= 1'b0; o_no_clip <= r_nc;
                        o_overflow <= r_ovf; o_last_out <= (r_j + CntW'(1) == r_cnt);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (!i_stall) begin
                    o_valid <= 1'b0;
                    if (o_last_out) begin
                        r_state <= S_LOAD; r_cnt <= '0; r_test <= 1'b0; r_ovf <= 1'b0;
                        r_bank <= 1'b0;
                    end else begin
                        r_j <= r_j + CntW'(1); r_state <= S_OWAIT;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("output while accepting");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxVerts)) else $error("count beyond capacity");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> o_last_out) else $error("empty not last");
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import uspc_pkg::*;

    localparam longint CoordOne = 65536;
    localparam int MaxCycles = 20_000_000;
    localparam int HoldCycles = 2500;
    localparam int DrainCycles = 60;

    // The four clip planes in the order the block applies them.
    typedef enum int {PlTBelowOne, PlSAboveZero, PlSBelowOne, PlTAboveZero} t_plane;

    // One vertex item as offered to the block. Rows marked as hand-checked carry
    // their expected result directly: a single empty-marked item.
    typedef struct {
        t_vtx v;
        bit   clip_test;
        bit   last_vertex;
        bit   hand_empty;
        bit   hand_ovf;
    } t_vertex_row;

    typedef struct {
        t_vtx       v;
        logic [6:0] cnt;
        bit         empty;
        bit         noclip;
        bit         ovf;
        bit         last;
    } t_clip_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic signed [23:0] i_light_u = '0;
    logic signed [23:0] i_light_v = '0;
    logic signed [23:0] i_tex_s = '0;
    logic signed [23:0] i_tex_t = '0;
    logic i_clip_test = 1'b0;
    logic i_last_vertex = 1'b0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic signed [31:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [23:0] o_out_light_u, o_out_light_v, o_out_tex_s, o_out_tex_t;
    logic [6:0] o_out_count;
    logic o_is_empty, o_no_clip, o_overflow, o_last_out;

    unit_square_polygon_clipper_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: the vertices of the polygon being loaded, whether the
    // full-quad test is armed, and whether capacity has been exceeded.
    t_vtx         poly_verts[$];
    bit           quad_test_armed;
    bit           poly_overflow;
    t_clip_result clip_expected[$];

    t_vertex_row  vertex_rows[$];
    int           mismatches;
    int           cycle_count;
    int           items_sent;
    bit           receiver_hold;

    // A vertex is kept by a plane only when it lies strictly inside it.
    function automatic bit keeps(t_plane pl, t_vtx v);
        case (pl)
            PlTBelowOne:  return longint'(v.tt) < CoordOne;
            PlSAboveZero: return longint'(v.ts) > 0;
            PlSBelowOne:  return longint'(v.ts) < CoordOne;
            default:      return longint'(v.tt) > 0;
        endcase
    endfunction

    // Exact fraction num/den between two end values, quotient truncated toward zero.
    function automatic longint lerp(longint x, longint y, longint num, longint den);
        return x + ((y - x) * num) / den;
    endfunction

    // Vertex where the edge from a to b meets the plane.
    function automatic t_vtx cut_edge(t_plane pl, t_vtx a, t_vtx b);
        longint num, den;
        t_vtx o;
        o = a;
        case (pl)
            PlTBelowOne: begin
                num = CoordOne - longint'(a.tt); den = longint'(b.tt) - longint'(a.tt);
            end
            PlSAboveZero: begin
                num = longint'(a.ts); den = longint'(a.ts) - longint'(b.ts);
            end
            PlSBelowOne: begin
                num = CoordOne - longint'(a.ts); den = longint'(b.ts) - longint'(a.ts);
            end
            default: begin
                num = longint'(a.tt); den = longint'(a.tt) - longint'(b.tt);
            end
        endcase
        if (den == 0) return o;
        o.px = 32'(lerp(a.px, b.px, num, den));
        o.py = 32'(lerp(a.py, b.py, num, den));
        o.pz = 32'(lerp(a.pz, b.pz, num, den));
        o.lu = 24'(lerp(a.lu, b.lu, num, den));
        o.lv = 24'(lerp(a.lv, b.lv, num, den));
        o.ts = 24'(lerp(a.ts, b.ts, num, den));
        o.tt = 24'(lerp(a.tt, b.tt, num, den));
        return o;
    endfunction

    function automatic void keep_vertex(inout t_vtx dst[$], input t_vtx v);
        if (dst.size() < MaxVerts) dst.push_back(v);
        else poly_overflow = 1'b1;
    endfunction

    // One Sutherland-Hodgman pass against a single plane.
    function automatic void clip_pass(t_plane pl, input t_vtx src[$], output t_vtx dst[$]);
        t_vtx s, p;
        dst = {};
        if (src.size() == 0) return;
        s = src[src.size() - 1];
        foreach (src[j]) begin
            p = src[j];
            if (keeps(pl, p)) begin
                if (!keeps(pl, s)) keep_vertex(dst, cut_edge(pl, s, p));
                keep_vertex(dst, p);
            end else if (keeps(pl, s)) begin
                keep_vertex(dst, cut_edge(pl, p, s));
            end
            s = p;
        end
    endfunction

    function automatic bit on_unit_edge(logic signed [23:0] c);
        return longint'(c) == 0 || longint'(c) == CoordOne;
    endfunction

    // Takes one accepted vertex; on the final vertex clips the polygon and queues
    // the expected items. Returns how many items were queued.
    function automatic int predict_vertex(t_vertex_row r);
        t_vtx a[$], b[$];
        t_clip_result res;
        bit noclip;
        if (r.clip_test) quad_test_armed = 1'b1;
        keep_vertex(poly_verts, r.v);
        if (!r.last_vertex) return 0;
        clip_pass(PlTBelowOne, poly_verts, b);
        clip_pass(PlSAboveZero, b, a);
        clip_pass(PlSBelowOne, a, b);
        clip_pass(PlTAboveZero, b, a);
        noclip = quad_test_armed && a.size() == 4;
        foreach (a[j]) if (!on_unit_edge(a[j].ts) || !on_unit_edge(a[j].tt)) noclip = 1'b0;
        res.ovf = poly_overflow;
        res.noclip = noclip;
        res.cnt = 7'(a.size());
        res.empty = a.size() == 0;
        if (a.size() == 0) begin
            res.v = '0;
            res.noclip = 1'b0;
            res.last = 1'b1;
            clip_expected.push_back(res);
        end
        foreach (a[j]) begin
            res.v = a[j];
            res.last = j == a.size() - 1;
            clip_expected.push_back(res);
        end
        poly_verts = {};
        quad_test_armed = 1'b0;
        poly_overflow = 1'b0;
        return a.size() == 0 ? 1 : a.size();
    endfunction

    function automatic t_vertex_row mk_row(longint px, longint py, longint pz, longint lu,
                                           longint lv, longint ts, longint tt, bit ct,
                                           bit last, bit hand_empty = 0, bit hand_ovf = 0);
        t_vertex_row r;
        r.v.px = 32'(px); r.v.py = 32'(py); r.v.pz = 32'(pz);
        r.v.lu = 24'(lu); r.v.lv = 24'(lv); r.v.ts = 24'(ts); r.v.tt = 24'(tt);
        r.clip_test = ct;
        r.last_vertex = last;
        r.hand_empty = hand_empty;
        r.hand_ovf = hand_ovf;
        return r;
    endfunction

    // Texture coordinate: mostly within a band around the unit square so that edges
    // cross the planes, sometimes exactly on an edge, sometimes anywhere in range.
    function automatic longint rand_coord(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 1) return $urandom_range(1, 65535);
        if (r < 10) return r < 5 ? 0 : CoordOne;
        if (r < 18) return longint'(24'($urandom));
        return longint'($urandom_range(0, 4 * 65536)) - 98304;
    endfunction

    function automatic t_vertex_row rand_row(int mode, longint ts, longint tt, bit last);
        return mk_row(longint'(32'($urandom)), longint'(32'($urandom)),
                      longint'(32'($urandom)), longint'(24'($urandom)),
                      longint'(24'($urandom)), ts, tt, $urandom_range(0, 7) == 0, last);
    endfunction

    // Builds one random polygon of a randomly chosen shape.
    function automatic void add_random_polygon();
        int kind, n;
        t_vertex_row r;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // Exact unit quad, rotated start, test armed on a random vertex.
            longint cs[4] = '{0, CoordOne, CoordOne, 0};
            longint ct[4] = '{0, 0, CoordOne, CoordOne};
            int rot = $urandom_range(0, 3);
            for (int j = 0; j < 4; j++) begin
                r = rand_row(0, cs[(j + rot) % 4], ct[(j + rot) % 4], j == 3);
                vertex_rows.push_back(r);
            end
            vertex_rows[vertex_rows.size() - 1 - $urandom_range(0, 3)].clip_test = 1'b1;
            return;
        end
        if (kind < 16) n = 1;
        else if (kind < 28) n = $urandom_range(2, 4);
        else n = $urandom_range(3, 8);
        for (int j = 0; j < n; j++) begin
            if (kind >= 16 && kind < 28)
                r = rand_row(1, rand_coord(1), rand_coord(1), j == n - 1);
            else
                r = rand_row(0, rand_coord(0), rand_coord(0), j == n - 1);
            vertex_rows.push_back(r);
        end
    endfunction

    // Too many input vertices: all inside, so no crossings slow the block down.
    function automatic void add_oversized_polygon();
        int n;
        n = MaxVerts + $urandom_range(1, 4);
        for (int j = 0; j < n; j++)
            vertex_rows.push_back(rand_row(1, rand_coord(1), rand_coord(1), j == n - 1));
    endfunction

    // Vertices alternate across t = 1, so the first pass produces more vertices than
    // the store holds.
    function automatic void add_growing_polygon();
        for (int j = 0; j < MaxVerts; j++)
            vertex_rows.push_back(rand_row(1, $urandom_range(6554, 58982),
                                           j[0] ? 98304 : 32768, j == MaxVerts - 1));
    endfunction

    int gap_steady;

    function automatic int pick_gap();
        int r;
        if (gap_steady > 0) begin
            gap_steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) gap_steady = $urandom_range(20, 60);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MaxCycles) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Once the run is under way, the receiver holds off for a long stretch while the
    // sender keeps offering items, so the block has to stall its input.
    initial begin
        receiver_hold = 1'b0;
        wait (items_sent >= 60);
        @(posedge i_clk);
        receiver_hold = 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        receiver_hold = 1'b0;
    end

    // Receiver: checks each accepted result item against the oldest expectation and
    // chooses the stall for the next cycle. The outputs are read in the active region
    // of the edge, before any register of the block has changed.
    initial begin
        t_clip_result got, want;
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.v = '{o_out_pos_x, o_out_pos_y, o_out_pos_z, o_out_light_u,
                          o_out_light_v, o_out_tex_s, o_out_tex_t};
                got.cnt = o_out_count;
                got.empty = o_is_empty;
                got.noclip = o_no_clip;
                got.ovf = o_overflow;
                got.last = o_last_out;
                if (clip_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: pos %h %h %h", got.v.px, got.v.py,
                                 got.v.pz);
                end else begin
                    want = clip_expected.pop_front();
                    if (got.v !== want.v || got.cnt !== want.cnt || got.empty !== want.empty
                        || got.noclip !== want.noclip || got.ovf !== want.ovf
                        || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch expected: pos %h %h %h lm %h %h st %h %h",
                                     want.v.px, want.v.py, want.v.pz, want.v.lu, want.v.lv,
                                     want.v.ts, want.v.tt, " cnt %0d e%b nc%b ov%b l%b",
                                     want.cnt, want.empty, want.noclip, want.ovf, want.last);
                            $display("         actual:   pos %h %h %h lm %h %h st %h %h",
                                     got.v.px, got.v.py, got.v.pz, got.v.lu, got.v.lv,
                                     got.v.ts, got.v.tt, " cnt %0d e%b nc%b ov%b l%b",
                                     got.cnt, got.empty, got.noclip, got.ovf, got.last);
                        end
                    end
                end
            end
            // Stall runs of random length, with calm stretches where it never stalls.
            if (receiver_hold) begin
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) calm_left = $urandom_range(30, 100);
                if (r < 60) stall_left = 0;
                else if (r < 90) stall_left = $urandom_range(1, 3);
                else if (r < 98) stall_left = $urandom_range(4, 15);
                else stall_left = $urandom_range(30, 90);
                i_stall <= stall_left > 0;
            end
        end
    end

    // Sender and run control.
    initial begin
        t_vertex_row row;
        int n_new, gap;
        t_clip_result hand;
        mismatches = 0;
        cycle_count = 0;
        items_sent = 0;
        gap_steady = 0;
        quad_test_armed = 1'b0;
        poly_overflow = 1'b0;

        // Directed part.
        // A single vertex inside the square comes back unchanged, fields at extremes.
        vertex_rows.push_back(mk_row(2147483647, -2147483648, 0, 8388607, -8388608,
                                     32768, 32768, 0, 1));
        // A triangle wholly above t = 1 clips away to one empty-marked item.
        vertex_rows.push_back(mk_row(1, 2, 3, 4, 5, 0, 131072, 0, 0));
        vertex_rows.push_back(mk_row(6, 7, 8, 9, 10, 65536, 131072, 0, 0));
        vertex_rows.push_back(mk_row(11, 12, 13, 14, 15, 32768, 196608, 0, 1, 1, 0));
        // The exact unit quad with the test armed raises no-clip.
        vertex_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 1, 0));
        vertex_rows.push_back(mk_row(256, 0, 0, 65536, 0, 65536, 0, 0, 0));
        vertex_rows.push_back(mk_row(256, 256, 0, 65536, 65536, 65536, 65536, 0, 0));
        vertex_rows.push_back(mk_row(0, 256, 0, 0, 65536, 0, 65536, 0, 1));
        // An oversized quad, test armed on a middle vertex, is cut down to the square.
        vertex_rows.push_back(mk_row(-512, -512, 100, -32768, -32768, -32768, -32768, 0, 0));
        vertex_rows.push_back(mk_row(512, -512, 200, 98304, -32768, 98304, -32768, 0, 0));
        vertex_rows.push_back(mk_row(512, 512, 300, 98304, 98304, 98304, 98304, 1, 0));
        vertex_rows.push_back(mk_row(-512, 512, 400, -32768, 98304, -32768, 98304, 0, 1));
        // Coordinates at the ends of their range, positions at the ends of theirs.
        vertex_rows.push_back(mk_row(-2147483648, 2147483647, -2147483648, -8388608,
                                     8388607, -8388608, 32768, 0, 0));
        vertex_rows.push_back(mk_row(2147483647, -2147483648, 2147483647, 8388607,
                                     -8388608, 8388607, 32768, 0, 0));
        vertex_rows.push_back(mk_row(-1, -1, -1, -1, -1, 32768, 8388607, 0, 1));
        // One vertex left of s = 0 clips away.
        vertex_rows.push_back(mk_row(5, 5, 5, 5, 5, -1, 32768, 1, 1, 1, 0));
        // A triangle wholly inside keeps all three vertices; the test fails on count.
        vertex_rows.push_back(mk_row(10, 20, 30, 40, 50, 1, 1, 1, 0));
        vertex_rows.push_back(mk_row(60, 70, 80, 90, 100, 65535, 1, 0, 0));
        vertex_rows.push_back(mk_row(110, 120, 130, 140, 150, 1, 65535, 0, 1));

        // Random part: mostly ordinary polygons, plus a few that exceed capacity.
        while (vertex_rows.size() < 350) begin
            if (vertex_rows.size() > 100 && vertex_rows.size() < 110) add_oversized_polygon();
            else if (vertex_rows.size() > 220 && vertex_rows.size() < 230) add_growing_polygon();
            else add_random_polygon();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vertex_rows[k]) begin
            row = vertex_rows[k];
            gap = pick_gap();
            if (gap > 0) begin
                if (k > 0) i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_pos_x <= row.v.px;
            i_pos_y <= row.v.py;
            i_pos_z <= row.v.pz;
            i_light_u <= row.v.lu;
            i_light_v <= row.v.lv;
            i_tex_s <= row.v.ts;
            i_tex_t <= row.v.tt;
            i_clip_test <= row.clip_test;
            i_last_vertex <= row.last_vertex;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            items_sent++;
            n_new = predict_vertex(row);
            if (row.hand_empty) begin
                // The predictor has to agree on the count; the item itself is hand-made.
                repeat (n_new) void'(clip_expected.pop_back());
                hand.v = '0;
                hand.cnt = '0;
                hand.empty = 1'b1;
                hand.noclip = 1'b0;
                hand.ovf = row.hand_ovf;
                hand.last = 1'b1;
                clip_expected.push_back(hand);
            end
        end
        i_valid <= 1'b0;

        while (clip_expected.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0 && clip_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
